// ----- sv/ppd_pkg.sv -----
// Shared types, codes and constants for the particle push and deposit core.
`default_nettype none
package ppd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CELL_W    = 15;
    localparam int DEPTH     = 32768;
    localparam int DEP_W     = 40;
    localparam int CRD_W     = 5;
    localparam int GRID_W    = 6;
    localparam int DIV_W     = 16;
    localparam int DCNT_W    = 5;
    localparam int WGT_W     = FRAC_BITS + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [1:0] OP_FIELD = 2'd0;
    localparam logic [1:0] OP_PUSH  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NZ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KZ = 3'd5;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_FWR, S_RD, S_RDW, S_DSTART, S_DWAIT,
        S_CA, S_CB, S_CC, S_CD, S_KICK, S_SPEED, S_MOVE, S_CELL, S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        DIV_Z, DIV_Y, DIV_X, WRAP_X, WRAP_Y, WRAP_Z
    } t_div_sel;

    typedef struct packed {
        logic              load;
        logic              fwr;
        logic              dep_rd;
        logic              dep_zero;
        logic              clr;
        logic [CELL_W-1:0] clr_addr;
        logic              div_start;
        t_div_sel          div_sel;
        logic              corner_addr;
        logic              corner_rd;
        logic              corner_mul;
        logic              corner_acc;
        logic              dep_mode;
        logic [2:0]        k;
        logic              kick;
        logic              speed;
        logic              move;
        logic              land_cell;
        logic              emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ----- sv/ppd_ctrl.sv -----
// Sequencer for the post-reset deposit clear, field writes, deposit reads and particle pushes.
`default_nettype none
module ppd_ctrl
    import ppd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic [1:0] i_op,
    input  wire t_sts       i_sts,
    output logic            o_s_tready,
    output t_cmd            o_cmd
);

    t_state            r_state, n_state;
    logic [CELL_W-1:0] r_clr, n_clr;
    logic [2:0]        r_k, n_k;
    logic              r_dep, n_dep;
    t_div_sel          r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_k     <= '0;
            r_dep   <= 1'b0;
            r_sel   <= DIV_Z;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_k     <= n_k;
            r_dep   <= n_dep;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_k     = r_k;
        n_dep   = r_dep;
        n_sel   = r_sel;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (&r_clr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (i_op)
                        OP_FIELD: n_state = S_FWR;
                        OP_PUSH: begin
                            n_state = S_DSTART;
                            n_sel   = DIV_Z;
                        end
                        OP_READ:  n_state = S_RD;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_FWR:    n_state = S_IDLE;
            S_RD:     n_state = S_RDW;
            S_RDW:    n_state = S_EMIT;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    if (r_sel == DIV_X) begin
                        n_state = S_CA;
                        n_k     = '0;
                        n_dep   = 1'b0;
                    end else if (r_sel == WRAP_Z) begin
                        n_state = S_CELL;
                    end else begin
                        n_sel   = t_div_sel'(r_sel + 3'd1);
                        n_state = S_DSTART;
                    end
                end
            end
            S_CA: n_state = S_CB;
            S_CB: n_state = S_CC;
            S_CC: n_state = S_CD;
            S_CD: begin
                if (r_k == 3'd7) begin
                    n_state = r_dep ? S_EMIT : S_KICK;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = S_CA;
                end
            end
            S_KICK:  n_state = S_SPEED;
            S_SPEED: n_state = S_MOVE;
            S_MOVE: begin
                n_sel   = WRAP_X;
                n_state = S_DSTART;
            end
            S_CELL: begin
                n_state = S_CA;
                n_k     = '0;
                n_dep   = 1'b1;
            end
            S_EMIT: if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.div_sel  = r_sel;
        o_cmd.k        = r_k;
        o_cmd.dep_mode = r_dep;
        o_cmd.clr_addr = r_clr;
        o_s_tready     = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clr = 1'b1;
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_FWR:    o_cmd.fwr         = 1'b1;
            S_RD:     o_cmd.dep_rd      = 1'b1;
            S_RDW:    o_cmd.dep_zero    = 1'b1;
            S_DSTART: o_cmd.div_start   = 1'b1;
            S_CA:     o_cmd.corner_addr = 1'b1;
            S_CB:     o_cmd.corner_rd   = 1'b1;
            S_CC:     o_cmd.corner_mul  = 1'b1;
            S_CD:     o_cmd.corner_acc  = 1'b1;
            S_KICK:   o_cmd.kick        = 1'b1;
            S_SPEED:  o_cmd.speed       = 1'b1;
            S_MOVE:   o_cmd.move        = 1'b1;
            S_CELL:   o_cmd.land_cell   = 1'b1;
            S_EMIT:   o_cmd.emit        = i_sts.out_free;
            default:  o_cmd.load        = 1'b0;
        endcase
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free) else $error("result loaded into full output");
    a_div_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> !i_sts.div_done) else $error("divider finished too early");
    a_gather_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CD && r_k == 3'd7 && !r_dep) |=> r_state == S_KICK)
        else $error("gather did not hand over to kick");
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready) else $error("transfer taken during clear");
`endif

endmodule
`default_nettype wire

// ----- sv/ppd_div.sv -----
// Restoring divider, one quotient bit per cycle, for cell decode and wrap.
`default_nettype none
module ppd_div
    import ppd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_W-1:0]  i_dividend,
    input  wire logic [GRID_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [DIV_W-1:0]       o_quot,
    output logic [GRID_W-1:0]      o_rem
);

    logic [DCNT_W-1:0] r_cnt;
    logic              r_done;
    logic [DIV_W-1:0]  r_quo;
    logic [GRID_W-1:0] r_rem, r_dvs;
    logic [GRID_W:0]   w_sh, w_diff;
    logic              w_ge;

    assign w_sh   = {r_rem, r_quo[DIV_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= DCNT_W'(DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[GRID_W-1:0] : w_sh[GRID_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ----- sv/ppd_dp.sv -----
// Datapath: registers, field and deposit stores, weights, gather, move, wrap.
`default_nettype none
module ppd_dp
    import ppd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_wdata,
    input  wire logic [287:0]         i_s_tdata,
    input  wire logic [1:0]           i_s_tuser,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [231:0]              o_m_tdata,
    output logic [0:0]                o_m_tuser
);

    localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

    // configuration
    logic [GRID_W-1:0]       r_n    [3];
    logic signed [31:0]      r_kick [3];

    // latched item
    logic [1:0]              r_op;
    logic [CELL_W-1:0]       r_cell_in;
    logic [CELL_W-1:0]       r_addr;
    logic [FRAC_BITS-1:0]    r_r    [3];
    logic [31:0]             r_spd_in [3];
    logic [95:0]             r_fld_in;
    logic [30:0]             r_id;

    // working state
    logic [CRD_W-1:0]        r_c    [3];
    logic [DIV_W-1:0]        r_q;
    logic [WGT_W-1:0]        r_wxy, r_w;
    logic [95:0]             r_fq;
    logic [DEP_W-1:0]        r_dq, r_dsum;
    logic signed [49:0]      r_prod [3];
    logic signed [49:0]      r_acc  [3];
    logic signed [63:0]      r_kp   [3];
    logic [31:0]             r_spd  [3];
    logic                    r_pneg [3];
    logic [DIV_W-1:0]        r_pmag [3];
    logic [CELL_W-1:0]       r_ncell;

    // output stage
    logic                    r_mv;
    logic                    r_o_kind;
    logic [CELL_W-1:0]       r_o_cell;
    logic [FRAC_BITS-1:0]    r_o_pos [3];
    logic [31:0]             r_o_spd [3];
    logic [30:0]             r_o_id;
    logic [DEP_W-1:0]        r_o_dep;

    logic [95:0]             m_field [DEPTH];
    logic [DEP_W-1:0]        m_dep   [DEPTH];

    function automatic logic [CELL_W-1:0] f_cell_addr(
        input logic [CRD_W-1:0] x, input logic [CRD_W-1:0] y, input logic [CRD_W-1:0] z,
        input logic [GRID_W-1:0] ny, input logic [GRID_W-1:0] nz);
        logic [10:0] v_xy;
        logic [16:0] v_all;
        v_xy  = 11'(x) * 11'(ny) + 11'(y);
        v_all = 17'(v_xy) * 17'(nz) + 17'(z);
        return v_all[CELL_W-1:0];
    endfunction

    function automatic logic [CRD_W-1:0] f_inc(input logic [CRD_W-1:0] c,
                                               input logic [GRID_W-1:0] n);
        logic [GRID_W-1:0] v_up;
        v_up = {1'b0, c} + 1'b1;
        return (v_up == n) ? '0 : v_up[CRD_W-1:0];
    endfunction

    function automatic logic [GRID_W-1:0] f_clamp(input logic [GRID_W-1:0] v);
        if (v == '0) return GRID_W'(1);
        if (v > GRID_W'(32)) return GRID_W'(32);
        return v;
    endfunction

    // divider operands and result steering
    logic              w_div_done;
    logic [DIV_W-1:0]  w_dvd, w_quot;
    logic [GRID_W-1:0] w_dvs, w_rem;
    logic [1:0]        w_ax;
    logic              w_is_wrap;
    logic [CRD_W-1:0]  w_wrap;

    always_comb begin
        w_ax      = 2'd0;
        w_is_wrap = 1'b0;
        w_dvd     = r_q;
        case (i_cmd.div_sel)
            DIV_Z: begin w_ax = 2'd2; w_dvd = {1'b0, r_cell_in}; end
            DIV_Y: w_ax = 2'd1;
            DIV_X: w_ax = 2'd0;
            WRAP_X: begin w_ax = 2'd0; w_is_wrap = 1'b1; end
            WRAP_Y: begin w_ax = 2'd1; w_is_wrap = 1'b1; end
            WRAP_Z: begin w_ax = 2'd2; w_is_wrap = 1'b1; end
            default: w_ax = 2'd0;
        endcase
        if (w_is_wrap) w_dvd = r_pmag[w_ax];
        w_dvs = r_n[w_ax];
        if (r_pneg[w_ax] && w_rem != '0) w_wrap = CRD_W'(r_n[w_ax] - w_rem);
        else if (r_pneg[w_ax])           w_wrap = '0;
        else                             w_wrap = w_rem[CRD_W-1:0];
    end

    ppd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // corner weights and addresses
    logic [CRD_W-1:0]     w_kx, w_ky, w_kz;
    logic [WGT_W-1:0]     w_wx, w_wy, w_wz;
    logic [2*WGT_W-1:0]   w_pxy, w_pw;
    logic [DEP_W:0]       w_dsum;
    logic signed [48:0]   w_s    [3];
    logic signed [33:0]   w_p    [3];
    logic [17:0]          w_pint [3];
    logic [17:0]          w_pabs [3];

    always_comb begin
        w_kx   = i_cmd.k[2] ? f_inc(r_c[0], r_n[0]) : r_c[0];
        w_ky   = i_cmd.k[1] ? f_inc(r_c[1], r_n[1]) : r_c[1];
        w_kz   = i_cmd.k[0] ? f_inc(r_c[2], r_n[2]) : r_c[2];
        w_wx   = i_cmd.k[2] ? {1'b0, r_r[0]} : ONE - {1'b0, r_r[0]};
        w_wy   = i_cmd.k[1] ? {1'b0, r_r[1]} : ONE - {1'b0, r_r[1]};
        w_wz   = i_cmd.k[0] ? {1'b0, r_r[2]} : ONE - {1'b0, r_r[2]};
        w_pxy  = (2*WGT_W)'(w_wx) * (2*WGT_W)'(w_wy);
        w_pw   = (2*WGT_W)'(r_wxy) * (2*WGT_W)'(w_wz);
        w_dsum = {1'b0, r_dq} + (DEP_W+1)'(r_w);
        for (int a = 0; a < 3; a++) begin
            w_s[a]    = {{17{r_spd_in[a][31]}}, r_spd_in[a]}
                      + {r_kp[a][63], r_kp[a][63:16]};
            w_p[a]    = $signed({13'b0, r_c[a], r_r[a]})
                      + $signed({{2{r_spd[a][31]}}, r_spd[a]});
            w_pint[a] = w_p[a][33:16];
            w_pabs[a] = w_pint[a][17] ? (~w_pint[a] + 18'd1) : w_pint[a];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_n[a]    <= GRID_W'(32);
                r_kick[a] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NX:  r_n[0]    <= f_clamp(i_cfg_wdata[GRID_W-1:0]);
                CFG_NY:  r_n[1]    <= f_clamp(i_cfg_wdata[GRID_W-1:0]);
                CFG_NZ:  r_n[2]    <= f_clamp(i_cfg_wdata[GRID_W-1:0]);
                CFG_KX:  r_kick[0] <= i_cfg_wdata;
                CFG_KY:  r_kick[1] <= i_cfg_wdata;
                CFG_KZ:  r_kick[2] <= i_cfg_wdata;
                default: r_n[0]    <= r_n[0];
            endcase
        end
    end

    // item registers and arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_s_tuser;
            r_cell_in   <= i_s_tdata[14:0];
            r_addr      <= i_s_tdata[14:0];
            r_r[0]      <= i_s_tdata[30:15];
            r_r[1]      <= i_s_tdata[46:31];
            r_r[2]      <= i_s_tdata[62:47];
            r_spd_in[0] <= i_s_tdata[94:63];
            r_spd_in[1] <= i_s_tdata[126:95];
            r_spd_in[2] <= i_s_tdata[158:127];
            r_fld_in    <= i_s_tdata[254:159];
            r_id        <= i_s_tdata[285:255];
            for (int a = 0; a < 3; a++) r_acc[a] <= '0;
        end
        if (w_div_done) begin
            if (w_is_wrap) begin
                r_c[w_ax] <= w_wrap;
            end else begin
                r_c[w_ax] <= w_rem[CRD_W-1:0];
                r_q       <= w_quot;
            end
        end
        if (i_cmd.corner_addr) begin
            r_addr <= f_cell_addr(w_kx, w_ky, w_kz, r_n[1], r_n[2]);
            r_wxy  <= w_pxy[2*FRAC_BITS:FRAC_BITS];
        end
        if (i_cmd.corner_rd) r_w <= w_pw[2*FRAC_BITS:FRAC_BITS];
        if (i_cmd.corner_mul) begin
            r_dsum <= w_dsum[DEP_W] ? '1 : w_dsum[DEP_W-1:0];
            for (int a = 0; a < 3; a++)
                r_prod[a] <= $signed({1'b0, r_w}) * $signed(r_fq[32*a +: 32]);
        end
        if (i_cmd.corner_acc && !i_cmd.dep_mode)
            for (int a = 0; a < 3; a++) r_acc[a] <= r_acc[a] + r_prod[a];
        if (i_cmd.kick)
            for (int a = 0; a < 3; a++)
                r_kp[a] <= $signed(r_acc[a][47:16]) * r_kick[a];
        if (i_cmd.speed)
            for (int a = 0; a < 3; a++) begin
                if (w_s[a][48:31] != {18{w_s[a][48]}})
                    r_spd[a] <= w_s[a][48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                else
                    r_spd[a] <= w_s[a][31:0];
            end
        if (i_cmd.move)
            for (int a = 0; a < 3; a++) begin
                r_pneg[a] <= w_pint[a][17];
                r_pmag[a] <= w_pabs[a][DIV_W-1:0];
                r_r[a]    <= w_p[a][15:0];
            end
        if (i_cmd.land_cell)
            r_ncell <= f_cell_addr(r_c[0], r_c[1], r_c[2], r_n[1], r_n[2]);
    end

    // field store
    always_ff @(posedge i_clk) begin
        if (i_cmd.fwr) m_field[r_addr] <= r_fld_in;
        if (i_cmd.corner_rd && !i_cmd.dep_mode) r_fq <= m_field[r_addr];
    end

    // deposit store, single port
    logic [CELL_W-1:0] w_daddr;
    logic              w_dwe, w_dre;
    logic [DEP_W-1:0]  w_dwd;

    assign w_daddr = i_cmd.clr ? i_cmd.clr_addr : r_addr;
    assign w_dwe   = i_cmd.clr | i_cmd.dep_zero | (i_cmd.corner_acc & i_cmd.dep_mode);
    assign w_dwd   = (i_cmd.corner_acc & i_cmd.dep_mode) ? r_dsum : '0;
    assign w_dre   = i_cmd.dep_rd | (i_cmd.corner_rd & i_cmd.dep_mode);

    always_ff @(posedge i_clk) begin
        if (w_dwe) m_dep[w_daddr] <= w_dwd;
        if (w_dre) r_dq <= m_dep[w_daddr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (i_cmd.emit) begin
            r_mv <= 1'b1;
        end else if (i_m_tready) begin
            r_mv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_op == OP_READ) begin
                r_o_kind <= 1'b1;
                r_o_cell <= r_cell_in;
                r_o_id   <= '0;
                r_o_dep  <= r_dq;
                for (int a = 0; a < 3; a++) begin
                    r_o_pos[a] <= '0;
                    r_o_spd[a] <= '0;
                end
            end else begin
                r_o_kind <= 1'b0;
                r_o_cell <= r_ncell;
                r_o_id   <= r_id;
                r_o_dep  <= '0;
                for (int a = 0; a < 3; a++) begin
                    r_o_pos[a] <= r_r[a];
                    r_o_spd[a] <= r_spd[a];
                end
            end
        end
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_mv || i_m_tready;
    assign o_m_tvalid     = r_mv;
    assign o_m_tuser      = r_o_kind;
    assign o_m_tdata      = {2'b00, r_o_dep, r_o_id, r_o_spd[2], r_o_spd[1], r_o_spd[0],
                             r_o_pos[2], r_o_pos[1], r_o_pos[0], r_o_cell};

endmodule
`default_nettype wire

// ----- sv/pic_particle_push_deposit_core.sv -----
// Top level of the periodic particle push and trilinear deposit core.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  s_tdata 288 b, s_tuser 2 b (op)
//  m_*       out        m_tvalid / m_tready  m_tdata 232 b, m_tuser 1 b (kind)
//  i_cfg_*   in         i_cfg_we             i_cfg_idx 3 b, i_cfg_wdata 32 b
//
// A deposit read and a push each wait for a free output register. A push consists
// of six divider runs (cell decode and wrap per axis) and two 8-corner passes,
// each corner stepping through address, read, multiply and accumulate, on
// single-port stores. After reset the deposit store is cleared; no transfer is
// taken meanwhile. A stalled result holds in the output register while the
// next transfer is taken.
`default_nettype none
module pic_particle_push_deposit_core
    import ppd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // cell_index, pos_x, pos_y, pos_z, speed_x, speed_y, speed_z,
    // field_x, field_y, field_z, particle_id, zero fill
    input  wire logic [287:0]         s_tdata,
    // op
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // new_cell, new_pos_x, new_pos_y, new_pos_z, new_speed_x, new_speed_y,
    // new_speed_z, moved_id, deposit_value, zero fill
    output logic [231:0]              m_tdata,
    // result_kind
    output logic [0:0]                m_tuser
);

    t_cmd w_cmd;
    t_sts w_sts;

    ppd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_op       (s_tuser),
        .i_sts      (w_sts),
        .o_s_tready (s_tready),
        .o_cmd      (w_cmd)
    );

    ppd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
